// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deque block, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define DREQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the cycle after the antecedent.
`define DREQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dreq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Action and status codes, field widths and the per-cell operation type.
// ----------------------------------------------------------------------------
package dreq_pkg;

  localparam int VALUE_W  = 32;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  // Action codes carried in the input tuser field.
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_REAR  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_REAR   = 2'd3;

  // Status codes carried in the output tuser field.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Operation broadcast to every cell; at most one member is set.
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cell_op_t;

endpackage

// ===== hdl/dreq_cell.sv =====
// ----------------------------------------------------------------------------
// Deque cell
// One slot of the packed deque chain. Shifts toward the rear on a front push,
// toward the front on a front pop, and acts as the rear slot when it is the
// boundary between occupied and free cells.
// ----------------------------------------------------------------------------
module dreq_cell
  import dreq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cell_op_t           op,
  input  logic [VALUE_W-1:0] value_in,
  input  logic [VALUE_W-1:0] left_data,
  input  logic               left_valid,
  input  logic [VALUE_W-1:0] right_data,
  input  logic               right_valid,
  output logic [VALUE_W-1:0] data_o,
  output logic               valid_o
);

  logic [VALUE_W-1:0] data_r;
  logic [VALUE_W-1:0] data_nxt;
  logic               valid_r;
  logic               valid_nxt;

  // Next contents of the slot for the broadcast operation.
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (op.push_front) begin
      data_nxt  = left_data;
      valid_nxt = left_valid;
    end else if (op.push_rear) begin
      // The first free slot behind an occupied one takes the new item.
      if (!valid_r && left_valid) begin
        data_nxt  = value_in;
        valid_nxt = 1'b1;
      end
    end else if (op.pop_front) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (op.pop_rear) begin
      // The last occupied slot is released.
      if (valid_r && !right_valid) begin
        valid_nxt = 1'b0;
      end
    end
  end

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Stored value.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o  = data_r;
  assign valid_o = valid_r;

endmodule

// ===== hdl/double_ended_ring_queue.sv =====
// Double-ended queue of DEPTH 32-bit items held in a chain of shifting cells.
// The result of a transaction is registered and presented in the cycle after it is accepted.
// Throughput: one transaction per cycle; the output register frees in the cycle
// its result is taken, so the input stalls only while the output stalls.
// Reset: synchronous active-low rst_n empties the queue and drops the output valid.
// ----------------------------------------------------------------------------
// Double-ended ring queue
// Push and pop at either end; full pushes and empty pops are refused with a
// status code. Items stay packed from cell 0 (front) toward the rear.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module double_ended_ring_queue
  import dreq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value_in
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value_out
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic [VALUE_W-1:0]  cell_data [DEPTH];
  logic [DEPTH-1:0]    cell_valid;
  logic [VALUE_W-1:0]  left_data [DEPTH];
  logic [DEPTH-1:0]    left_valid;
  logic [VALUE_W-1:0]  right_data [DEPTH];
  logic [DEPTH-1:0]    right_valid;

  logic                accept;
  logic                is_push;
  logic                is_pop;
  logic                q_empty;
  logic                q_full;
  cell_op_t            op;
  logic [VALUE_W-1:0]  rear_data;
  logic [VALUE_W-1:0]  res_value;
  logic [STATUS_W-1:0] res_status;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [DEPTH:0]      valid_ext;
  logic [DEPTH:0]      valid_inc;

  // Input transaction and queue condition.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_push   = (in_tuser == ACT_PUSH_FRONT) || (in_tuser == ACT_PUSH_REAR);
  assign is_pop    = !is_push;
  assign q_empty   = !cell_valid[0];
  assign q_full    = cell_valid[DEPTH-1];

  // Operation broadcast to the chain.
  always_comb begin
    op.push_front = accept && (in_tuser == ACT_PUSH_FRONT) && !q_full;
    op.push_rear  = accept && (in_tuser == ACT_PUSH_REAR)  && !q_full;
    op.pop_front  = accept && (in_tuser == ACT_POP_FRONT)  && !q_empty;
    op.pop_rear   = accept && (in_tuser == ACT_POP_REAR)   && !q_empty;
  end

  // Neighbor wiring: the front end is fed by the incoming value, the rear end
  // sees an empty slot beyond it.
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_front
        assign left_data[gi]  = in_tdata;
        assign left_valid[gi] = 1'b1;
      end else begin : g_inner_l
        assign left_data[gi]  = cell_data[gi-1];
        assign left_valid[gi] = cell_valid[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_rear
        assign right_data[gi]  = '0;
        assign right_valid[gi] = 1'b0;
      end else begin : g_inner_r
        assign right_data[gi]  = cell_data[gi+1];
        assign right_valid[gi] = cell_valid[gi+1];
      end

      dreq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .value_in    (in_tdata),
        .left_data   (left_data[gi]),
        .left_valid  (left_valid[gi]),
        .right_data  (right_data[gi]),
        .right_valid (right_valid[gi]),
        .data_o      (cell_data[gi]),
        .valid_o     (cell_valid[gi])
      );
    end
  endgenerate

  // Rear item: the single occupied cell whose right neighbor is free.
  always_comb begin
    rear_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_valid[i] && !right_valid[i]) begin
        rear_data = rear_data | cell_data[i];
      end
    end
  end

  // Result of the current transaction.
  always_comb begin
    res_value  = '0;
    res_status = ST_DONE;
    if (is_push && q_full) begin
      res_status = ST_FULL;
    end else if (is_pop && q_empty) begin
      res_status = ST_EMPTY;
    end else if (op.pop_front) begin
      res_value = cell_data[0];
    end else if (op.pop_rear) begin
      res_value = rear_data;
    end
  end

  // Output register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  // Occupancy must stay packed toward the front.
  assign valid_ext = {1'b0, cell_valid};
  assign valid_inc = valid_ext + {{DEPTH{1'b0}}, 1'b1};

  `DREQ_ASSERT_ALWAYS(a_packed, (valid_ext & valid_inc) == '0, "deque cells not packed")
  `DREQ_ASSERT_NEXT(a_full_refused, accept && is_push && q_full, out_tuser == ST_FULL, "full push not refused")
  `DREQ_ASSERT_NEXT(a_empty_refused, accept && is_pop && q_empty, (out_tuser == ST_EMPTY) && (out_tdata == '0), "empty pop not refused")
  `DREQ_ASSERT_NEXT(a_push_fills, accept && is_push && !q_full, cell_valid[0] && (out_tuser == ST_DONE), "push left queue empty")

endmodule
